### src/circular_path_kinematics_core_defines.svh
// assertion macros shared by the checker of the kinematics core
// no dependencies; expects clk and rst_n in the scope of use
`ifndef CIRCULAR_PATH_KINEMATICS_CORE_DEFINES_SVH
`define CIRCULAR_PATH_KINEMATICS_CORE_DEFINES_SVH

// property that must hold at every edge outside reset
`define CPK_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// next-cycle implication, also checked while reset is applied
`define CPK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### src/cpk_pkg.sv
// shared constants, types and helper functions of the kinematics core
// no dependencies
package cpk_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int ANGW             = 34;
  localparam int MAGW             = 34;

  localparam logic [63:0] TWO_PI_Q56  = 64'h06487ED5110B4611;
  localparam logic [63:0] HALF_PI_Q56 = 64'h01921FB54442D184;

  typedef logic signed [ANGW-1:0] ang_t;
  typedef logic [MAGW-1:0] mag_t;

  localparam ang_t GAIN_Q30 = 34'sh26DD3B6A;

  typedef enum logic [1:0] {
    CFG_OMEGA  = 2'd0,
    CFG_RADIUS = 2'd1,
    CFG_START  = 2'd2
  } cfg_idx_t;

  // arctangent of 2^-i in Q4.30, truncated
  function automatic ang_t atan_entry(input int unsigned i);
    ang_t a;
    case (i)
      0: a = 34'sh3243F6A8;
      1: a = 34'sh1DAC6705;
      2: a = 34'sh0FADBAFC;
      3: a = 34'sh07F56EA6;
      4: a = 34'sh03FEAB76;
      5: a = 34'sh01FFD55B;
      6: a = 34'sh00FFFAAA;
      7: a = 34'sh007FFF55;
      8: a = 34'sh003FFFEA;
      9: a = 34'sh001FFFFD;
      default: begin
        if (i <= 30) a = ang_t'((64'd1 << (30 - i)) - 64'd1);
        else a = '0;
      end
    endcase
    return a;
  endfunction

  // sign and magnitude to saturated 32-bit two's complement
  function automatic logic [31:0] sat32(input logic neg, input logic [63:0] mag);
    logic [31:0] res;
    if (neg) begin
      if (mag >= 64'h80000000) res = 32'h80000000;
      else res = 32'(64'd0 - mag);
    end else begin
      if (mag > 64'h7FFFFFFF) res = 32'h7FFFFFFF;
      else res = mag[31:0];
    end
    return res;
  endfunction

endpackage

### src/cpk_mod_cell.sv
// one cell of the phase reduction chain: conditional subtract of a shifted 2*pi
// depends on nothing beyond its parameters
module cpk_mod_cell #(
  parameter int PW = 65,
  parameter logic [PW-1:0] DIV = '1,
  parameter int SHIFT = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_i,
  input  logic [PW-1:0] rem_i,
  output logic          vld_o,
  output logic [PW-1:0] rem_o
);

  localparam logic [PW-1:0] STEP_DIV = DIV << SHIFT;

  logic          vld_r;
  logic [PW-1:0] rem_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_i;
  end

  // restoring subtract
  always_ff @(posedge clk) begin
    rem_r <= (rem_i >= STEP_DIV) ? rem_i - STEP_DIV : rem_i;
  end

  assign vld_o = vld_r;
  assign rem_o = rem_r;

endmodule

### src/cpk_cordic_cell.sv
// one rotation cell of the sine/cosine chain
// depends on cpk_pkg for the angle type and arctangent table
module cpk_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_i,
  input  cpk_pkg::ang_t x_i,
  input  cpk_pkg::ang_t y_i,
  input  cpk_pkg::ang_t z_i,
  input  logic [1:0]    quad_i,
  output logic          vld_o,
  output cpk_pkg::ang_t x_o,
  output cpk_pkg::ang_t y_o,
  output cpk_pkg::ang_t z_o,
  output logic [1:0]    quad_o
);

  localparam cpk_pkg::ang_t ATAN = cpk_pkg::atan_entry(STEP);

  logic          vld_r;
  cpk_pkg::ang_t x_r, y_r, z_r;
  logic [1:0]    quad_r;
  cpk_pkg::ang_t dx, dy;

  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_i;
  end

  // rotate toward zero residual angle
  always_ff @(posedge clk) begin
    quad_r <= quad_i;
    if (!z_i[cpk_pkg::ANGW-1]) begin
      x_r <= x_i - dx;
      y_r <= y_i + dy;
      z_r <= z_i - ATAN;
    end else begin
      x_r <= x_i + dx;
      y_r <= y_i - dy;
      z_r <= z_i + ATAN;
    end
  end

  assign vld_o  = vld_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign quad_o = quad_r;

endmodule

### src/cpk_mul.sv
// two-stage unsigned multiplier with truncating right shift
// a wider than 32 bits is split at bit 32 into two partial products; no dependencies
module cpk_mul #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int SH = 0
) (
  input  logic                 clk,
  input  logic [AW-1:0]        a,
  input  logic [BW-1:0]        b,
  output logic [AW+BW-SH-1:0]  p
);

  logic [AW+BW-1:0]    sum;
  logic [AW+BW-SH-1:0] p_r;

  generate
    if (AW > 32) begin : g_split
      logic [32+BW-1:0]    lo_r;
      logic [AW-32+BW-1:0] hi_r;
      // partial products
      always_ff @(posedge clk) begin
        lo_r <= a[31:0] * b;
        hi_r <= a[AW-1:32] * b;
      end
      assign sum = {hi_r, 32'd0} + (AW+BW)'(lo_r);
    end else begin : g_single
      logic [AW+BW-1:0] pr_r;
      always_ff @(posedge clk) begin
        pr_r <= a * b;
      end
      assign sum = pr_r;
    end
  endgenerate

  // align and register
  always_ff @(posedge clk) begin
    p_r <= sum[AW+BW-1:SH];
  end

  assign p = p_r;

endmodule

### src/circular_path_kinematics_core.sv
// Circular-path kinematics core: one time sample in, position, velocity,
// acceleration and jerk for x and y out. A sample is taken in every clock
// cycle (busy stays low) and its result appears on the out_ ports, marked by
// out_valid for one cycle, with no way to stall it. The path runs through the
// chain of phase reduction cells (one conditional subtract of 2*pi per cell),
// the chain of CORDIC rotation cells (one rotation per cell) and two
// pipelined multiplier levels. Configuration writes are always ready and are
// to be made with no sample in flight.
// depends on cpk_pkg, cpk_mod_cell, cpk_cordic_cell, cpk_mul
module circular_path_kinematics_core #(
  parameter int CORDIC_STEPS = cpk_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = cpk_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        in_sample_time,
  output logic               out_valid,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic signed [31:0] out_acc_x,
  output logic signed [31:0] out_acc_y,
  output logic signed [31:0] out_jerk_x,
  output logic signed [31:0] out_jerk_y,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int TW = 33;
  localparam int PW = TW + 32;
  localparam logic [63:0] FULL64 = cpk_pkg::TWO_PI_Q56 >> (32 - FRAC_BITS);
  localparam logic [63:0] QTR64  = cpk_pkg::HALF_PI_Q56 >> (32 - FRAC_BITS);
  localparam int FULLW = $clog2(FULL64 + 64'd1);
  localparam int NCELL = PW - FULLW + 1;
  localparam logic [PW-1:0] FULL_P = PW'(FULL64);
  localparam logic [PW-1:0] Q1 = PW'(QTR64);
  localparam logic [PW-1:0] Q2 = PW'(QTR64 * 64'd2);
  localparam logic [PW-1:0] Q3 = PW'(QTR64 * 64'd3);

  // configuration registers
  logic [31:0] omega_r, radius_r, start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      omega_r  <= '0;
      radius_r <= '0;
      start_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cpk_pkg::cfg_idx_t'(cfg_index))
        cpk_pkg::CFG_OMEGA:  omega_r  <= cfg_data;
        cpk_pkg::CFG_RADIUS: radius_r <= cfg_data;
        cpk_pkg::CFG_START:  start_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  // sign and magnitude of rate and radius
  logic        w_neg, r_neg;
  logic [31:0] w_mag, r_mag;
  assign w_neg = omega_r[31];
  assign r_neg = radius_r[31];
  assign w_mag = w_neg ? 32'(-omega_r) : omega_r;
  assign r_mag = r_neg ? 32'(-radius_r) : radius_r;

  // rate powers, recomputed continuously from the registers
  logic [39:0] w2_mag;
  logic [47:0] w3_mag;
  cpk_mul #(.AW(32), .BW(32), .SH(24)) u_w2 (.clk(clk), .a(w_mag), .b(w_mag), .p(w2_mag));
  cpk_mul #(.AW(40), .BW(32), .SH(24)) u_w3 (.clk(clk), .a(w2_mag), .b(w_mag), .p(w3_mag));

  // time offset and phase product
  logic          v0_r, v1_r;
  logic [TW-1:0] t_r;
  logic [PW-1:0] ph_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    t_r  <= TW'(in_sample_time) + TW'(start_r);
    ph_r <= w_mag * t_r;
  end

  // phase reduction chain
  logic          vm_c [0:NCELL];
  logic [PW-1:0] rm_c [0:NCELL];
  assign vm_c[0] = v1_r;
  assign rm_c[0] = ph_r;

  generate
    for (genvar j = 0; j < NCELL; j++) begin : g_mod
      cpk_mod_cell #(.PW(PW), .DIV(FULL_P), .SHIFT(NCELL - 1 - j)) u_cell (
        .clk(clk), .rst_n(rst_n),
        .vld_i(vm_c[j]), .rem_i(rm_c[j]),
        .vld_o(vm_c[j+1]), .rem_o(rm_c[j+1])
      );
    end
  endgenerate

  // negative rate mirror, then quadrant split
  logic          vqa_r, vqb_r;
  logic [PW-1:0] rem2_r;
  cpk_pkg::ang_t z0_r;
  logic [1:0]    quad0_r;
  logic [PW-1:0] rem_in;

  assign rem_in = rm_c[NCELL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vqa_r <= 1'b0;
      vqb_r <= 1'b0;
    end else begin
      vqa_r <= vm_c[NCELL];
      vqb_r <= vqa_r;
    end
  end

  always_ff @(posedge clk) begin
    rem2_r <= (w_neg && rem_in != '0) ? FULL_P - rem_in : rem_in;
    if (rem2_r >= Q3) begin
      quad0_r <= 2'd3;
      z0_r    <= cpk_pkg::ang_t'((rem2_r - Q3) >> (FRAC_BITS - 6));
    end else if (rem2_r >= Q2) begin
      quad0_r <= 2'd2;
      z0_r    <= cpk_pkg::ang_t'((rem2_r - Q2) >> (FRAC_BITS - 6));
    end else if (rem2_r >= Q1) begin
      quad0_r <= 2'd1;
      z0_r    <= cpk_pkg::ang_t'((rem2_r - Q1) >> (FRAC_BITS - 6));
    end else begin
      quad0_r <= 2'd0;
      z0_r    <= cpk_pkg::ang_t'(rem2_r >> (FRAC_BITS - 6));
    end
  end

  // cordic rotation chain
  logic          vc_c [0:CORDIC_STEPS];
  cpk_pkg::ang_t xc_c [0:CORDIC_STEPS];
  cpk_pkg::ang_t yc_c [0:CORDIC_STEPS];
  cpk_pkg::ang_t zc_c [0:CORDIC_STEPS];
  logic [1:0]    qc_c [0:CORDIC_STEPS];

  assign vc_c[0] = vqb_r;
  assign xc_c[0] = cpk_pkg::GAIN_Q30;
  assign yc_c[0] = '0;
  assign zc_c[0] = z0_r;
  assign qc_c[0] = quad0_r;

  generate
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      cpk_cordic_cell #(.STEP(i)) u_cell (
        .clk(clk), .rst_n(rst_n),
        .vld_i(vc_c[i]), .x_i(xc_c[i]), .y_i(yc_c[i]), .z_i(zc_c[i]), .quad_i(qc_c[i]),
        .vld_o(vc_c[i+1]), .x_o(xc_c[i+1]), .y_o(yc_c[i+1]), .z_o(zc_c[i+1]),
        .quad_o(qc_c[i+1])
      );
    end
  endgenerate

  // quadrant mapping to sine and cosine magnitudes
  cpk_pkg::ang_t cx, cy, sn, cs;
  logic          vmap_r, sneg_r, cneg_r;
  cpk_pkg::mag_t smag_r, cmag_r;

  assign cx = xc_c[CORDIC_STEPS];
  assign cy = yc_c[CORDIC_STEPS];

  always_comb begin
    case (qc_c[CORDIC_STEPS])
      2'd0: begin sn = cy;  cs = cx;  end
      2'd1: begin sn = cx;  cs = -cy; end
      2'd2: begin sn = -cy; cs = -cx; end
      default: begin sn = -cx; cs = cy; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vmap_r <= 1'b0;
    else vmap_r <= vc_c[CORDIC_STEPS];
  end

  always_ff @(posedge clk) begin
    sneg_r <= sn[cpk_pkg::ANGW-1];
    cneg_r <= cs[cpk_pkg::ANGW-1];
    smag_r <= sn[cpk_pkg::ANGW-1] ? cpk_pkg::mag_t'(-sn) : cpk_pkg::mag_t'(sn);
    cmag_r <= cs[cpk_pkg::ANGW-1] ? cpk_pkg::mag_t'(-cs) : cpk_pkg::mag_t'(cs);
  end

  // first multiplier level
  logic [35:0] rs_p, rc_p, ws_p, wc_p;
  logic [43:0] w2s_p, w2c_p;
  logic [51:0] w3s_p, w3c_p;

  cpk_mul #(.AW(32), .BW(34), .SH(30)) u_rs  (.clk(clk), .a(r_mag),  .b(smag_r), .p(rs_p));
  cpk_mul #(.AW(32), .BW(34), .SH(30)) u_rc  (.clk(clk), .a(r_mag),  .b(cmag_r), .p(rc_p));
  cpk_mul #(.AW(32), .BW(34), .SH(30)) u_ws  (.clk(clk), .a(w_mag),  .b(smag_r), .p(ws_p));
  cpk_mul #(.AW(32), .BW(34), .SH(30)) u_wc  (.clk(clk), .a(w_mag),  .b(cmag_r), .p(wc_p));
  cpk_mul #(.AW(40), .BW(34), .SH(30)) u_w2s (.clk(clk), .a(w2_mag), .b(smag_r), .p(w2s_p));
  cpk_mul #(.AW(40), .BW(34), .SH(30)) u_w2c (.clk(clk), .a(w2_mag), .b(cmag_r), .p(w2c_p));
  cpk_mul #(.AW(48), .BW(34), .SH(30)) u_w3s (.clk(clk), .a(w3_mag), .b(smag_r), .p(w3s_p));
  cpk_mul #(.AW(48), .BW(34), .SH(30)) u_w3c (.clk(clk), .a(w3_mag), .b(cmag_r), .p(w3c_p));

  // second multiplier level, times radius
  logic [43:0] vx_p, vy_p;
  logic [51:0] ax_p, ay_p;
  logic [59:0] jx_p, jy_p;

  cpk_mul #(.AW(36), .BW(32), .SH(24)) u_vx (.clk(clk), .a(wc_p),  .b(r_mag), .p(vx_p));
  cpk_mul #(.AW(36), .BW(32), .SH(24)) u_vy (.clk(clk), .a(ws_p),  .b(r_mag), .p(vy_p));
  cpk_mul #(.AW(44), .BW(32), .SH(24)) u_ax (.clk(clk), .a(w2s_p), .b(r_mag), .p(ax_p));
  cpk_mul #(.AW(44), .BW(32), .SH(24)) u_ay (.clk(clk), .a(w2c_p), .b(r_mag), .p(ay_p));
  cpk_mul #(.AW(52), .BW(32), .SH(24)) u_jx (.clk(clk), .a(w3c_p), .b(r_mag), .p(jx_p));
  cpk_mul #(.AW(52), .BW(32), .SH(24)) u_jy (.clk(clk), .a(w3s_p), .b(r_mag), .p(jy_p));

  // align position, signs and strobe with the second level
  logic [3:0]  vd_r, sd_r, cd_r;
  logic [35:0] px_d_r [0:1];
  logic [35:0] py_d_r [0:1];

  always_ff @(posedge clk) begin
    if (!rst_n) vd_r <= '0;
    else vd_r <= {vd_r[2:0], vmap_r};
  end

  always_ff @(posedge clk) begin
    sd_r      <= {sd_r[2:0], sneg_r};
    cd_r      <= {cd_r[2:0], cneg_r};
    px_d_r[0] <= rs_p;
    px_d_r[1] <= px_d_r[0];
    py_d_r[0] <= rc_p;
    py_d_r[1] <= py_d_r[0];
  end

  // saturation and result register
  logic        sg, cg, out_valid_r;
  logic [31:0] px_r, py_r, vx_r, vy_r, ax_r, ay_r, jx_r, jy_r;

  assign sg = sd_r[3];
  assign cg = cd_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= vd_r[3];
  end

  always_ff @(posedge clk) begin
    px_r <= cpk_pkg::sat32(r_neg ^ sg, 64'(px_d_r[1]));
    py_r <= cpk_pkg::sat32(r_neg ^ cg, 64'(py_d_r[1]));
    vx_r <= cpk_pkg::sat32(w_neg ^ cg ^ r_neg, 64'(vx_p));
    vy_r <= cpk_pkg::sat32(!(w_neg ^ sg ^ r_neg), 64'(vy_p));
    ax_r <= cpk_pkg::sat32(!(sg ^ r_neg), 64'(ax_p));
    ay_r <= cpk_pkg::sat32(!(cg ^ r_neg), 64'(ay_p));
    jx_r <= cpk_pkg::sat32(!(w_neg ^ cg ^ r_neg), 64'(jx_p));
    jy_r <= cpk_pkg::sat32(w_neg ^ sg ^ r_neg, 64'(jy_p));
  end

  assign out_valid  = out_valid_r;
  assign out_pos_x  = px_r;
  assign out_pos_y  = py_r;
  assign out_vel_x  = vx_r;
  assign out_vel_y  = vy_r;
  assign out_acc_x  = ax_r;
  assign out_acc_y  = ay_r;
  assign out_jerk_x = jx_r;
  assign out_jerk_y = jy_r;

endmodule

### src/cpk_checker.sv
// port-level checks of the kinematics core, bound to the top level
// depends on circular_path_kinematics_core_defines.svh
`include "circular_path_kinematics_core_defines.svh"

module cpk_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid,
  input logic cfg_ready
);

  // the pipeline never refuses a transaction
  `CPK_ASSERT_ALWAYS(a_never_busy, !busy, "core reported busy")
  // configuration writes are always taken
  `CPK_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "configuration port not ready")
  // reset drops the result strobe
  `CPK_ASSERT_NEXT(a_rst_strobe, !rst_n, !out_valid, "result strobe after reset")
  // reset flushes the pipeline: no result right after it
  `CPK_ASSERT_NEXT(a_rst_flush, !rst_n && $past(!rst_n), !out_valid, "pipeline not flushed")

endmodule

bind circular_path_kinematics_core cpk_checker u_cpk_checker (
  .clk(clk),
  .rst_n(rst_n),
  .busy(busy),
  .out_valid(out_valid),
  .cfg_ready(cfg_ready)
);
